FILE: hdl/hfp_pkg.sv
// ----------------------------------------------------------------------------
// hfp_pkg
// Types and constants shared by the table bit packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hfp_pkg;

  localparam int VALUE_W          = 32;  // width of a code value field
  localparam int LEN_W            = 6;   // width of a code length field
  localparam int BYTE_W           = 8;
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int OPQ_DEPTH        = 4;
  localparam int OUTQ_DEPTH       = 2;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         symbol;
    logic [LEN_W-1:0]   code_length;
    logic [VALUE_W-1:0] code_value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_pad_count;
    logic              last;
  } out_item_t;

  // Work handed from the table front end to the packer.
  typedef struct packed {
    logic               fin;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] code;
  } op_t;

endpackage

`default_nettype wire

FILE: hdl/hfp_fifo.sv
// ----------------------------------------------------------------------------
// hfp_fifo
// Small first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hfp_front.sv
// ----------------------------------------------------------------------------
// hfp_front
// Code table and item classifier: loads entries, looks up codes for source
// bytes and forwards encode and finish work to the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hfp_front
  import hfp_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_item,
  output logic          in_full,
  output op_t           op,
  output logic          op_push,
  input  wire logic     op_full
);

  localparam int CAP = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int LW  = $clog2(CAP + 1);

  logic [LW-1:0]    len_mem  [256];
  logic [CAP-1:0]   code_mem [256];
  logic [255:0]     vld_r;
  logic             s1_v_r;
  logic             s1_fin_r;
  logic             rd_hit_r;
  logic [LW-1:0]    rd_len_r;
  logic [CAP-1:0]   rd_code_r;
  logic             accept;
  logic             is_load, is_enc, is_fin;
  logic [LEN_W-1:0] sat_len;
  logic [VALUE_W-1:0] mask;
  logic             has_work;

  assign in_full = s1_v_r && op_full;
  assign accept  = in_push && !in_full;
  assign is_load = (in_item.kind == KIND_LOAD);
  assign is_enc  = (in_item.kind == KIND_ENCODE);
  assign is_fin  = (in_item.kind == KIND_FINISH);

  assign sat_len = (in_item.code_length > LEN_W'(CAP)) ? LEN_W'(CAP) : in_item.code_length;
  // Code bits above the stored length are dropped before they reach the table.
  assign mask    = ~({VALUE_W{1'b1}} << sat_len);

  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      len_mem[in_item.symbol]  <= LW'(sat_len);
      code_mem[in_item.symbol] <= mask[CAP-1:0] & in_item.code_value[CAP-1:0];
    end
    if (accept && is_enc) begin
      rd_len_r  <= len_mem[in_item.symbol];
      rd_code_r <= code_mem[in_item.symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s1_v_r   <= 1'b0;
      s1_fin_r <= 1'b0;
      rd_hit_r <= 1'b0;
    end else begin
      if (accept && is_load) begin
        vld_r[in_item.symbol] <= 1'b1;
      end
      if (!in_full) begin
        s1_v_r   <= accept && (is_enc || is_fin);
        s1_fin_r <= is_fin;
        rd_hit_r <= vld_r[in_item.symbol];
      end
    end
  end

  // A symbol without a code leaves the stage without producing work.
  assign has_work = s1_fin_r || (rd_hit_r && (rd_len_r != '0));
  assign op_push  = s1_v_r && has_work && !op_full;

  always_comb begin
    op      = '0;
    op.fin  = s1_fin_r;
    op.len  = rd_hit_r ? LEN_W'(rd_len_r) : '0;
    op.code = VALUE_W'(rd_code_r);
  end

endmodule

`default_nettype wire

FILE: hdl/hfp_back.sv
// ----------------------------------------------------------------------------
// hfp_back
// Bit packer: appends codes MSB-first to the pending bits, emits full bytes,
// one per cycle when res_full is low; on finish flushes, writes pad count.
// ----------------------------------------------------------------------------
`default_nettype none

module hfp_back
  import hfp_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire op_t  op,
  input  wire logic op_empty,
  output logic      op_pop,
  output out_item_t res,
  output logic      res_push,
  input  wire logic res_full
);

  localparam int CAP = (MAX_CODE_LEN < VALUE_W) ? MAX_CODE_LEN : VALUE_W;
  localparam int BW  = CAP + 7;
  // The bit count must also hold the constant 16 that it is compared against.
  localparam int TW  = ($clog2(BW + 1) > 5) ? $clog2(BW + 1) : 5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_PAD  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [6:0]    pend_r, pend_nxt;   // pending bits, left-aligned
  logic [2:0]    cnt_r, cnt_nxt;
  logic [BW-1:0] buf_r, buf_nxt;     // bits still to emit, left-aligned
  logic [TW-1:0] tot_r, tot_nxt;
  logic [2:0]    pad_r, pad_nxt;

  logic [BW-1:0] code_ext;
  logic [TW-1:0] sh;
  logic [BW-1:0] new_buf;
  logic [TW-1:0] new_tot;

  assign code_ext = BW'(op.code[CAP-1:0]);
  assign sh       = TW'(BW) - TW'(cnt_r) - TW'(op.len);
  assign new_buf  = {pend_r, {(BW-7){1'b0}}} | (code_ext << sh);
  assign new_tot  = TW'(cnt_r) + TW'(op.len);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    buf_nxt   = buf_r;
    tot_nxt   = tot_r;
    pad_nxt   = pad_r;
    op_pop    = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        if (!op_empty && !res_full) begin
          op_pop = 1'b1;
          if (op.fin) begin
            res_push = 1'b1;
            pend_nxt = '0;
            cnt_nxt  = '0;
            if (cnt_r != '0) begin
              res.out_byte = {pend_r, 1'b0};
              pad_nxt      = 3'(4'd8 - {1'b0, cnt_r});
              state_nxt    = ST_PAD;
            end else begin
              res.is_pad_count = 1'b1;
              res.last         = 1'b1;
            end
          end else if (new_tot < TW'(8)) begin
            pend_nxt = new_buf[BW-1 -: 7];
            cnt_nxt  = new_tot[2:0];
          end else begin
            res_push     = 1'b1;
            res.out_byte = new_buf[BW-1 -: 8];
            res.last     = (new_tot < TW'(16));
            if (new_tot < TW'(16)) begin
              pend_nxt = new_buf[BW-9 -: 7];
              cnt_nxt  = new_tot[2:0];
            end else begin
              buf_nxt   = new_buf << 8;
              tot_nxt   = new_tot - TW'(8);
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push     = 1'b1;
          res.out_byte = buf_r[BW-1 -: 8];
          res.last     = (tot_r < TW'(16));
          if (tot_r < TW'(16)) begin
            pend_nxt  = buf_r[BW-9 -: 7];
            cnt_nxt   = tot_r[2:0];
            state_nxt = ST_IDLE;
          end else begin
            buf_nxt = buf_r << 8;
            tot_nxt = tot_r - TW'(8);
          end
        end
      end
      ST_PAD: begin
        if (!res_full) begin
          res_push         = 1'b1;
          res.out_byte     = {5'd0, pad_r};
          res.is_pad_count = 1'b1;
          res.last         = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    tot_r <= tot_nxt;
    pad_r <= pad_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/huffman_table_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_packer
// Table-driven code packer: 256-entry code table, MSB-first byte output.
// ----------------------------------------------------------------------------
// Both channels look like queues. Push an item with in_push while in_full is
// low; take results from out_item while out_empty is low, acknowledging each
// beat with out_pop. A load item writes one table entry and gives no result.
// An encode item gives 0 to 4 packed bytes; a finish item gives an optional
// flush byte and then the pad-count byte, and restarts the bit buffer.
// The last beat caused by an item has last set.
// Path: the table read of an accepted item is registered, its work passes
// through the work queue, and the packer writes the result queue in the
// cycle that it takes the work. The packer emits one byte per cycle while
// the result queue has room; table loads and symbols without a code never
// reach the packer. A four-entry work queue lets the front keep accepting
// while the packer is busy.
// Reset clears all code lengths at once through per-entry valid bits, and
// empties the pending bits; code values are undefined until loaded.
// When the receiver stops popping, the two-entry result queue fills, the
// packer stalls, then the work queue, and finally in_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_bit_packer
  import hfp_pkg::*;
#(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  input  wire in_item_t  in_item,
  output logic           in_full,
  output out_item_t      out_item,
  output logic           out_empty,
  input  wire logic      out_pop
);

  op_t       op_in, op_out;
  logic      op_push, op_pop, op_full, op_empty;
  out_item_t res;
  logic      res_push, res_full;

  hfp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .op      (op_in),
    .op_push (op_push),
    .op_full (op_full)
  );

  hfp_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_out),
    .empty (op_empty)
  );

  hfp_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op_out),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  hfp_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

  // The front never offers work that the queue cannot take.
  a_op_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    op_push |-> !op_full)
    else $error("work queue pushed while full");

  // The packer never produces a beat that the result queue cannot take.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue pushed while full");

  // A pad-count beat closes its item and carries a count below eight.
  a_pad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.is_pad_count) |-> (out_item.last && out_item.out_byte[7:3] == 5'd0))
    else $error("malformed pad-count beat");

endmodule

`default_nettype wire

FILE: verif/huffman_table_bit_packer_tb.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_packer_tb
// Self-checking bench for the table-driven code packer.
// A short stimulus table covers the field extremes, the no-code case, the
// unused kind, length saturation and both flush shapes. Random traffic then
// loads codes and encodes mostly loaded symbols, with finishes and noise.
// Every output beat is checked against its row's beats or an in-bench model.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfp_pkg::*;

  localparam int MAX_LEN        = DEF_MAX_CODE_LEN;
  localparam int CODE_CAP       = (MAX_LEN < VALUE_W) ? MAX_LEN : VALUE_W;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PHASE_ITEMS    = 135;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam out_item_t NO_RES = '0;

  typedef struct packed {
    in_item_t          item;
    logic              typed;    // expected beats come from the row, not the model
    logic [2:0]        n_res;
    out_item_t [3:0]   res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_item;
  logic      in_full;
  out_item_t out_item;
  logic      out_empty;
  logic      out_pop;

  // Model state of the packer.
  logic [LEN_W-1:0]   len_tab  [256];
  logic [VALUE_W-1:0] code_tab [256];
  logic [6:0]         pend_bits;
  logic [2:0]         pend_cnt;

  out_item_t  expected_bytes [$];
  stim_row_t  directed_rows  [$];
  logic [7:0] known_syms     [$];
  int         errors;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_req;
  int         hold_left;
  int         quiet_cycles;

  huffman_table_bit_packer #(
    .MAX_CODE_LEN(MAX_LEN)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_item (out_item),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic in_item_t mk_item(logic [1:0] k, logic [7:0] s, logic [5:0] l,
                                       logic [31:0] v);
    in_item_t it;
    it.kind        = k;
    it.symbol      = s;
    it.code_length = l;
    it.code_value  = v;
    return it;
  endfunction

  function automatic out_item_t ob(logic [7:0] b, logic pad, logic lst);
    out_item_t r;
    r.out_byte     = b;
    r.is_pad_count = pad;
    r.last         = lst;
    return r;
  endfunction

  task automatic add_row(input in_item_t it, input logic typed, input int n,
                         input out_item_t [3:0] rs);
    stim_row_t r;
    r.item  = it;
    r.typed = typed;
    r.n_res = 3'(n);
    r.res   = rs;
    directed_rows.push_back(r);
  endtask

  // Updates the model state and returns the beats one input item causes.
  function automatic int predict_packed_bytes(input in_item_t it,
                                              output out_item_t [3:0] res);
    int n;
    int l;
    int total;
    int pad;
    logic [63:0] acc;
    n   = 0;
    res = '0;
    case (it.kind)
      KIND_LOAD: begin
        l = (int'(it.code_length) > CODE_CAP) ? CODE_CAP : int'(it.code_length);
        len_tab[it.symbol]  = LEN_W'(l);
        code_tab[it.symbol] = it.code_value;
      end
      KIND_ENCODE: begin
        l = int'(len_tab[it.symbol]);
        if (l > CODE_CAP) l = CODE_CAP;
        if (l != 0) begin
          acc = (64'(pend_bits) << l) |
                (64'(code_tab[it.symbol]) & ((64'd1 << l) - 64'd1));
          total = int'(pend_cnt) + l;
          while (total >= 8 && n < 4) begin
            res[n] = ob(8'(acc >> (total - 8)), 1'b0, 1'b0);
            n++;
            total -= 8;
          end
          pend_cnt  = 3'(total);
          pend_bits = 7'(acc & ((64'd1 << pend_cnt) - 64'd1));
          if (n > 0) res[n-1].last = 1'b1;
        end
      end
      KIND_FINISH: begin
        pad = 0;
        if (pend_cnt != 3'd0) begin
          pad    = 8 - int'(pend_cnt);
          res[n] = ob(8'(16'(pend_bits) << pad), 1'b0, 1'b0);
          n++;
        end
        res[n] = ob(8'(pad), 1'b1, 1'b1);
        n++;
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  // Mostly encodes of loaded symbols, with some loads and finishes,
  // encodes of arbitrary symbols and the occasional unused kind.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick;
    int lsel;
    r       = '0;
    pick    = $urandom_range(99);
    r.item  = mk_item(KIND_ENCODE, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      $urandom());
    if (pick < 15) begin
      r.item.kind = KIND_LOAD;
      lsel = $urandom_range(99);
      if (lsel < 5)       r.item.code_length = 6'd0;
      else if (lsel < 10) r.item.code_length = 6'($urandom_range(63, 33));
      else if (lsel < 30) r.item.code_length = 6'($urandom_range(32, 13));
      else                r.item.code_length = 6'($urandom_range(12, 1));
      known_syms.push_back(r.item.symbol);
    end else if (pick < 93) begin
      if (known_syms.size() > 0 && $urandom_range(99) < 85)
        r.item.symbol = known_syms[$urandom_range(known_syms.size() - 1)];
    end else if (pick < 98) begin
      r.item.kind = KIND_FINISH;
    end else begin
      r.item.kind = KIND_UNUSED;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // Offers one beat, waits for it to be taken and records what it should cause.
  task automatic push_beat(input stim_row_t r);
    out_item_t [3:0] pred;
    int n;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= r.item;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n = predict_packed_bytes(r.item, pred);
    if (r.typed) begin
      for (int i = 0; i < int'(r.n_res); i++) expected_bytes.push_back(r.res[i]);
    end else begin
      for (int i = 0; i < n; i++) expected_bytes.push_back(pred[i]);
    end
  endtask

  // Receiver: random pops, or a long hold-off when one is requested.
  initial begin
    out_pop   = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("beat with nothing expected", out_item.out_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_item.out_byte, want.out_byte);
        if (out_item.is_pad_count !== want.is_pad_count)
          report_mismatch("is_pad_count", 8'(out_item.is_pad_count), 8'(want.is_pad_count));
        if (out_item.last !== want.last)
          report_mismatch("last", 8'(out_item.last), 8'(want.last));
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[huffman_table_bit_packer] ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    stim_row_t row;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_item      = '0;
    errors       = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct  = 10;
    rx_idle_pct  = 69;
    pend_bits    = '0;
    pend_cnt     = '0;
    for (int i = 0; i < 256; i++) begin
      len_tab[i]  = '0;
      code_tab[i] = '0;
    end

    // After reset the buffer is empty and no symbol has a code.
    add_row(mk_item(KIND_FINISH, 8'h00, 6'd0, 32'h0), 1'b1, 1,
            {NO_RES, NO_RES, NO_RES, ob(8'h00, 1'b1, 1'b1)});
    add_row(mk_item(KIND_ENCODE, 8'h41, 6'd0, 32'h0), 1'b1, 0, {4{NO_RES}});
    add_row(mk_item(KIND_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF), 1'b1, 0, {4{NO_RES}});
    add_row(mk_item(KIND_LOAD, 8'h00, 6'd32, 32'hFFFF_FFFF), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_LOAD, 8'hFF, 6'd1, 32'hFFFF_FFFF), 1'b0, 0, {4{NO_RES}});
    // Overlong length saturates to the full code width.
    add_row(mk_item(KIND_LOAD, 8'h80, 6'd63, 32'hA5A5_A5A5), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_LOAD, 8'h01, 6'd7, 32'hDEAD_BE55), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_LOAD, 8'h02, 6'd0, 32'h1234_5678), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_LOAD, 8'h7F, 6'd32, 32'h0000_0000), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h00, 6'd0, 32'h0), 1'b1, 4,
            {ob(8'hFF, 1'b0, 1'b1), ob(8'hFF, 1'b0, 1'b0),
             ob(8'hFF, 1'b0, 1'b0), ob(8'hFF, 1'b0, 1'b0)});
    add_row(mk_item(KIND_ENCODE, 8'hFF, 6'h3F, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h01, 6'd0, 32'hFFFF_FFFF), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h02, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h80, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'hFF, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h7F, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_FINISH, 8'h00, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_FINISH, 8'hFF, 6'h3F, 32'hFFFF_FFFF), 1'b1, 1,
            {NO_RES, NO_RES, NO_RES, ob(8'h00, 1'b1, 1'b1)});
    // Seven pending bits plus a full-width code fill four bytes.
    add_row(mk_item(KIND_ENCODE, 8'h01, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_ENCODE, 8'h00, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});
    add_row(mk_item(KIND_FINISH, 8'h00, 6'd0, 32'h0), 1'b0, 0, {4{NO_RES}});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) push_beat(directed_rows[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        row = random_row();
        push_beat(row);
        if (row.item.kind != KIND_UNUSED) sent++;
      end
    end
    @(negedge clk);
    in_push <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[huffman_table_bit_packer] OK");
    end else begin
      $display("[huffman_table_bit_packer] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hfp_pkg.sv
hdl/hfp_fifo.sv
hdl/hfp_front.sv
hdl/hfp_back.sv
hdl/huffman_table_bit_packer.sv
verif/huffman_table_bit_packer_tb.sv
